// ----- design/ohtab_pkg.sv -----
// Shared types and constants for the open-addressing hash table.
`default_nettype none
package ohtab_pkg;
	localparam int SLOTS = 256;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = SLOT_W + 1;

	typedef enum logic [1:0] {
		FUNC_SET    = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_GET    = 2'd2,
		FUNC_REMOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_USED  = 2'd1,
		TAG_TOMB  = 2'd2,
		TAG_RSVD  = 2'd3
	} tag_t;

	localparam logic [2:0] ST_MISS     = 3'd0;
	localparam logic [2:0] ST_HIT      = 3'd1;
	localparam logic [2:0] ST_NEW      = 3'd2;
	localparam logic [2:0] ST_REPLACED = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture request, set probe at home slot
		logic step;       // advance probe position and count
		logic eval;       // examine read data of current slot
		logic commit;     // apply result writes
		logic done;       // capture get-hit value; result strobe follows
		logic clr;        // clear pass write
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic stop;       // probe ended (empty, match or all slots read)
		logic clr_last;   // clear pass at final slot
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- design/ohtab_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module ohtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- design/ohtab_dp.sv -----
// Datapath: request registers, tag/key/value memories, probe tracking and counters.
`default_nettype none
module ohtab_dp
	import ohtab_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] key,
	input  wire logic [31:0] hash,
	input  wire logic [63:0] value_in,
	input  wire logic        load_limit_we,
	input  wire logic [7:0]  load_limit_wdata,
	output dp_stat_t         stat,
	output logic [2:0]       status,
	output logic [63:0]      value_out,
	output logic [7:0]       slot
);
	logic [1:0]        func_q;
	logic [63:0]       key_q, val_q;
	logic [SLOT_W-1:0] pos_q, clr_q;
	logic [CNT_W-1:0]  n_q;
	logic              found_q, empty_q, tomb_q;
	logic [SLOT_W-1:0] found_at_q, empty_at_q, tomb_at_q;
	logic [8:0]        used_q, tombs_q;
	logic [7:0]        limit_q;

	logic [1:0]  tag_rd;
	logic [63:0] key_rd, val_rd;
	logic              tag_we, kv_we, v_we;
	logic [SLOT_W-1:0] waddr;
	logic [1:0]        tag_wd;

	logic [SLOT_W-1:0] raddr;
	assign raddr = cmd.commit ? found_at_q : pos_q;

	ohtab_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_tag (
		.clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wd),
		.raddr(raddr), .rdata(tag_rd));
	ohtab_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
		.clk(clk), .we(kv_we), .waddr(waddr), .wdata(key_q),
		.raddr(raddr), .rdata(key_rd));
	ohtab_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
		.clk(clk), .we(v_we), .waddr(waddr), .wdata(val_q),
		.raddr(raddr), .rdata(val_rd));

	// Probe evaluation of the slot just read.
	logic hit_now, empty_now, tomb_now, last_now;
	assign empty_now = (tag_rd == TAG_EMPTY);
	assign tomb_now  = (tag_rd == TAG_TOMB);
	assign hit_now   = (tag_rd == TAG_USED) && (key_rd == key_q);
	assign last_now  = (n_q == CNT_W'(SLOTS - 1));
	assign stat.stop = cmd.eval && (empty_now || hit_now || last_now);
	assign stat.clr_last = (clr_q == SLOT_W'(SLOTS - 1));

	// Result decision, valid in commit cycle.
	logic is_set, do_repl, do_tomb, do_empty, tomb_ins;
	assign is_set   = (func_q == FUNC_SET);
	assign tomb_ins = is_set && !found_q && tomb_q;
	assign do_empty = is_set && !found_q && !tomb_q && empty_q && (used_q < {1'b0, limit_q});
	assign do_repl  = found_q && (func_q == FUNC_SET || func_q == FUNC_UPDATE);
	assign do_tomb  = found_q && (func_q == FUNC_REMOVE);

	always_comb begin
		tag_we = 1'b0;
		kv_we  = 1'b0;
		v_we   = 1'b0;
		waddr  = found_at_q;
		tag_wd = TAG_USED;
		if (cmd.clr) begin
			tag_we = 1'b1;
			waddr  = clr_q;
			tag_wd = TAG_EMPTY;
		end else if (cmd.commit) begin
			if (do_repl) begin
				v_we = 1'b1;
			end else if (do_tomb) begin
				tag_we = 1'b1;
				tag_wd = TAG_TOMB;
			end else if (tomb_ins) begin
				tag_we = 1'b1; kv_we = 1'b1; v_we = 1'b1;
				waddr = tomb_at_q;
			end else if (do_empty) begin
				tag_we = 1'b1; kv_we = 1'b1; v_we = 1'b1;
				waddr = empty_at_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			tombs_q <= '0;
			limit_q <= 8'd192;
			clr_q   <= '0;
			status  <= ST_MISS;
			value_out <= '0;
			slot    <= '0;
		end else begin
			if (load_limit_we)
				limit_q <= load_limit_wdata;
			if (cmd.clr)
				clr_q <= clr_q + SLOT_W'(1);
			if (cmd.commit) begin
				if (tomb_ins && tombs_q != '0)
					tombs_q <= tombs_q - 9'd1;
				if (do_tomb)
					tombs_q <= tombs_q + 9'd1;
				if (do_empty)
					used_q <= used_q + 9'd1;
			end
			if (cmd.commit) begin
				value_out <= '0;
				slot      <= '0;
				if (is_set) begin
					if (found_q) begin
						status <= ST_REPLACED; slot <= 8'(found_at_q);
					end else if (tomb_q) begin
						status <= ST_NEW; slot <= 8'(tomb_at_q);
					end else if (do_empty) begin
						status <= ST_NEW; slot <= 8'(empty_at_q);
					end else begin
						status <= ST_FULL;
					end
				end else if (found_q) begin
					status <= ST_HIT;
					slot <= 8'(found_at_q);
				end else begin
					status <= ST_MISS;
				end
			end
			// Value read for a get hit arrives in the cycle after commit, in the done state.
			if (cmd.done && func_q == FUNC_GET && found_q)
				value_out <= val_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			key_q    <= key;
			val_q    <= value_in;
			pos_q    <= hash[SLOT_W-1:0];
			n_q      <= '0;
			found_q  <= 1'b0;
			empty_q  <= 1'b0;
			tomb_q   <= 1'b0;
		end else if (cmd.eval) begin
			if (empty_now) begin
				empty_q <= 1'b1; empty_at_q <= pos_q;
			end else if (hit_now) begin
				found_q <= 1'b1; found_at_q <= pos_q;
			end else if (tomb_now && !tomb_q) begin
				tomb_q <= 1'b1; tomb_at_q <= pos_q;
			end
			if (cmd.step) begin
				pos_q <= pos_q + SLOT_W'(1);
				n_q   <= n_q + CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/ohtab_ctl.sv -----
// Controller state machine sequencing clear pass, probe, commit and result.
`default_nettype none
module ohtab_ctl
	import ohtab_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd,
	output logic          busy,
	output logic          done
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_EVAL, S_COMMIT, S_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:  cmd.clr = 1'b1;
			S_IDLE:   cmd.load = start;
			S_READ:   cmd = '0;
			S_EVAL: begin
				cmd.eval = 1'b1;
				cmd.step = !stat.stop;
			end
			S_COMMIT: cmd.commit = 1'b1;
			S_DONE:   cmd.done = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy    <= 1'b1;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: if (stat.clr_last) begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				S_IDLE: if (start) begin
					state_q <= S_READ;
					busy    <= 1'b1;
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: state_q <= stat.stop ? S_COMMIT : S_READ;
				S_COMMIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
					done    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/open_addressing_hash_table_top.sv -----
// Top level of the open-addressing hash table.
// Usage: drive func, key, hash and value_in with start high; the request
// transfers at a rising edge where start is high and busy is low. Busy stays
// high until the result is out. The result (status, value_out, slot) is valid
// for one cycle while done is high; the receiver cannot stall it.
// Each slot probed takes a read state (memory read) and then an eval state
// (compare); then follow the commit state, the done state and the done
// strobe. Busy is already low in the done cycle, so the next transfer can
// come at that same edge. A probe reads up to all SLOTS slots when the table
// is crowded. The read state per slot is needed because the tag and key
// memories have a registered read.
// Reset: tags are swept to empty one slot per cycle with busy high; counters
// clear and load_limit returns to 192. load_limit_we writes load_limit at
// any edge, and should be used only while idle.
`default_nettype none
module open_addressing_hash_table_top
	import ohtab_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] key,
	input  wire logic [31:0] hash,
	input  wire logic [63:0] value_in,
	input  wire logic        load_limit_we,
	input  wire logic [7:0]  load_limit_wdata,
	output logic             done,
	output logic [2:0]       status,
	output logic [63:0]      value_out,
	output logic [7:0]       slot
);
	ctl_cmd_t cmd;
	dp_stat_t stat;

	ohtab_ctl u_ctl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done));

	ohtab_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .func(func), .key(key),
		.hash(hash), .value_in(value_in),
		.load_limit_we(load_limit_we), .load_limit_wdata(load_limit_wdata),
		.stat(stat), .status(status), .value_out(value_out), .slot(slot));

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after transfer");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_FULL)) else $error("status code out of range");
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the open-addressing hash table: random and directed requests with a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import ohtab_pkg::*;

	typedef struct packed {
		logic [2:0]  st;
		logic [63:0] val;
		logic [7:0]  idx;
	} answer_t;

	class table_scoreboard;
		tag_t        tags [SLOTS];
		logic [63:0] keys [SLOTS];
		logic [63:0] vals [SLOTS];
		int unsigned used_cnt, tomb_cnt, limit;
		answer_t     pending [$];
		int unsigned errors, checked;

		function void clear_table();
			foreach (tags[i]) tags[i] = TAG_EMPTY;
			used_cnt = 0;
			tomb_cnt = 0;
			limit = 192;
		endfunction

		function void note_request(func_t f, logic [63:0] k, logic [31:0] h, logic [63:0] v);
			int unsigned pos, n, hit_at, empty_at, tomb_at;
			bit hit, have_empty, have_tomb;
			answer_t a;
			hit = 0; have_empty = 0; have_tomb = 0;
			hit_at = 0; empty_at = 0; tomb_at = 0;
			a = '0;
			pos = h % SLOTS;
			for (n = 0; n < SLOTS; n++) begin
				if (tags[pos] == TAG_EMPTY) begin
					have_empty = 1; empty_at = pos; break;
				end
				if (tags[pos] == TAG_TOMB) begin
					if (!have_tomb) begin
						have_tomb = 1; tomb_at = pos;
					end
				end else if (tags[pos] == TAG_USED && keys[pos] == k) begin
					hit = 1; hit_at = pos; break;
				end
				pos = (pos + 1) % SLOTS;
			end
			a.st = ST_MISS;
			if (f == FUNC_SET) begin
				if (hit) begin
					vals[hit_at] = v; a.st = ST_REPLACED; a.idx = hit_at[7:0];
				end else if (have_tomb) begin
					tags[tomb_at] = TAG_USED; keys[tomb_at] = k; vals[tomb_at] = v;
					if (tomb_cnt > 0) tomb_cnt--;
					a.st = ST_NEW; a.idx = tomb_at[7:0];
				end else if (have_empty && used_cnt < limit) begin
					tags[empty_at] = TAG_USED; keys[empty_at] = k; vals[empty_at] = v;
					used_cnt = (used_cnt + 1) & 9'h1ff;
					a.st = ST_NEW; a.idx = empty_at[7:0];
				end else a.st = ST_FULL;
			end else if (hit) begin
				a.st = ST_HIT; a.idx = hit_at[7:0];
				if (f == FUNC_UPDATE) vals[hit_at] = v;
				else if (f == FUNC_GET) a.val = vals[hit_at];
				else begin
					tags[hit_at] = TAG_TOMB;
					tomb_cnt = (tomb_cnt + 1) & 9'h1ff;
				end
			end
			pending.push_back(a);
		endfunction

		function void check_answer(logic [2:0] s, logic [63:0] v, logic [7:0] i);
			answer_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d value=%h slot=%0d", $time, s, v, i);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (s !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, s); errors++;
			end
			if (v !== e.val) begin
				$display("%0t: value_out expected %h actual %h", $time, e.val, v); errors++;
			end
			if (i !== e.idx) begin
				$display("%0t: slot expected %0d actual %0d", $time, e.idx, i); errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, start, busy, done;
	logic [1:0]  func;
	logic [63:0] key, value_in, value_out;
	logic [31:0] hash;
	logic        load_limit_we;
	logic [7:0]  load_limit_wdata, slot;
	logic [2:0]  status;

	table_scoreboard sb;
	logic [63:0] key_pool [16];
	logic [31:0] hash_pool [16];
	int unsigned n_sent, n_full, n_tomb_reuse;

	open_addressing_hash_table_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .key(key), .hash(hash), .value_in(value_in),
		.load_limit_we(load_limit_we), .load_limit_wdata(load_limit_wdata),
		.done(done), .status(status), .value_out(value_out), .slot(slot)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_answer(status, value_out, slot);
	end

	// Hold start until the transfer, then note it; start drops at the transfer edge,
	// so the next request is driven from the following edge.
	task automatic send(func_t f, logic [63:0] k, logic [31:0] h, logic [63:0] v);
		@(posedge clk);
		start <= 1'b1; func <= f; key <= k; hash <= h; value_in <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(f, k, h, v);
		n_sent++;
		start <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(logic [7:0] lim);
		drain();
		load_limit_we <= 1'b1; load_limit_wdata <= lim;
		@(posedge clk);
		load_limit_we <= 1'b0;
		sb.limit = lim;
	endtask

	// Random request from a small key pool, whose hashes may be clustered.
	task automatic random_request(bit lo_hash);
		int unsigned p;
		logic [63:0] k;
		logic [31:0] h;
		p = $urandom_range(0, 15);
		k = key_pool[p];
		h = hash_pool[p];
		if ($urandom_range(0, 9) == 0) begin
			k = {$urandom, $urandom};
			h = lo_hash ? $urandom_range(0, 7) : $urandom;
		end
		send(func_t'($urandom_range(0, 3)), k, h, {$urandom, $urandom});
		if (sb.pending.size() != 0 && sb.pending[$].st == ST_FULL) n_full++;
	endtask

	task automatic refill_pool(bit clustered);
		foreach (key_pool[i]) begin
			key_pool[i] = {$urandom, $urandom};
			hash_pool[i] = clustered ? {$urandom_range(0, 1) ? 24'hffffff : 24'($urandom),
				8'($urandom_range(250, 255))} : $urandom;
		end
	endtask

	initial begin
		int unsigned burst, i, ph;
		sb = new();
		sb.clear_table();
		start = 0; func = FUNC_SET; key = '0; hash = '0; value_in = '0;
		load_limit_we = 0; load_limit_wdata = 8'd0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every operation, tombstone reuse, wrap, full.
		send(FUNC_GET, '0, '0, '0);
		send(FUNC_SET, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
		send(FUNC_SET, 64'h0, 32'hffff_ffff, 64'h0);
		send(FUNC_SET, 64'h1, 32'h0000_00ff, 64'h1234);
		send(FUNC_GET, 64'h1, 32'h0000_00ff, '0);
		send(FUNC_GET, 64'h0, 32'hffff_ffff, '1);
		send(FUNC_UPDATE, 64'h0, 32'hffff_ffff, 64'haaaa_5555_aaaa_5555);
		send(FUNC_UPDATE, 64'h77, 32'h0, 64'h1);
		send(FUNC_SET, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 64'h5555);
		send(FUNC_REMOVE, 64'h0, 32'hffff_ffff, '0);
		send(FUNC_REMOVE, 64'h0, 32'hffff_ffff, '0);
		send(FUNC_GET, 64'h1, 32'h0000_00ff, '0);
		send(FUNC_SET, 64'h99, 32'h0000_00ff, 64'h99);
		send(FUNC_GET, 64'h99, 32'h0000_00ff, '0);
		set_limit(8'd3);
		send(FUNC_SET, 64'h123, 32'h10, 64'h1);
		send(FUNC_SET, 64'h124, 32'h10, 64'h2);
		send(FUNC_REMOVE, 64'h123, 32'h10, '0);
		send(FUNC_SET, 64'h125, 32'h10, 64'h3);
		send(FUNC_SET, 64'h126, 32'h10, 64'h4);
		set_limit(8'd1);
		send(FUNC_SET, 64'h200, 32'h20, 64'h5);
		set_limit(8'd255);

		// Random phases with varied load limits and clustering.
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: set_limit(8'd255);
				1: set_limit(8'($urandom_range(1, 254)));
				2: set_limit(8'd1);
				default: set_limit(8'($urandom_range(200, 255)));
			endcase
			refill_pool(ph[0]);
			i = 0;
			while (i < 235) begin
				burst = $urandom_range(1, 20);
				repeat (burst) begin
					random_request(ph[1]);
					i++;
				end
				if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end

		drain();
		repeat (600) @(posedge clk);
		$display("Sent %0d requests over 8 load-limit phases; %0d checked, %0d refused as full.",
			n_sent, sb.checked, n_full);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ----- open_addressing_hash_table_top.f -----
design/ohtab_pkg.sv
design/ohtab_ram.sv
design/ohtab_dp.sv
design/ohtab_ctl.sv
design/open_addressing_hash_table_top.sv
tb/sv/tb_top.sv
